// ----- sv/rodlq_pkg.sv -----
// ----------------------------------------------------------------------------
// rodlq_pkg: shared types and constants for the line request queue
// Holds the queue geometry, the entry and result records, the control bus
// that drives the cell chain, and the count saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rodlq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W   = 6;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Request kinds carried on the input tuser bit.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Admission policies.
  localparam logic POL_OVERLAP = 1'b0;
  localparam logic POL_REPLACE = 1'b1;

  typedef struct packed {
    logic        policy;
    logic [7:0]  group;
    logic        voice;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic                 shift;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    entry_t               wr_data;
  } cell_ctl_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] depth;
    logic                 head_policy;
    logic [7:0]           head_group;
    logic                 head_voice;
    logic [15:0]          head_tag;
    logic                 head_valid;
    logic                 overflow_drop;
    logic [OUT_CNT_W-1:0] replaced_count;
    logic                 accepted;
  } result_t;

  // Clamp a count to the largest value of the result count fields.
  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    logic [CNT_W+OUT_CNT_W-1:0] lim;
    logic [OUT_CNT_W-1:0]       r;
    w   = {{OUT_CNT_W{1'b0}}, v};
    lim = {{CNT_W{1'b0}}, {OUT_CNT_W{1'b1}}};
    if (w > lim) begin
      r = {OUT_CNT_W{1'b1}};
    end else begin
      r = w[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rodlq_cell.sv -----
// ----------------------------------------------------------------------------
// rodlq_cell: one queue slot
// Holds one entry. Loads a written entry when addressed, otherwise takes its
// upper neighbor's entry when the chain shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module rodlq_cell (
  input  wire logic                        clk,
  input  wire rodlq_pkg::cell_ctl_t        ctl,
  input  wire logic [rodlq_pkg::IDX_W-1:0] cell_idx,
  input  wire rodlq_pkg::entry_t           nbr_in,
  output rodlq_pkg::entry_t                entry_q
);

  rodlq_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      entry_r <= ctl.wr_data;
    end else if (ctl.shift) begin
      entry_r <= nbr_in;
    end
  end

  assign entry_q = entry_r;

endmodule

`default_nettype wire

// ----- sv/rodlq_chain.sv -----
// ----------------------------------------------------------------------------
// rodlq_chain: row of queue slots
// Cell zero is the head. On a shift every cell takes its upper neighbor's
// entry; a write lands in the one addressed cell in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rodlq_chain (
  input  wire logic                 clk,
  input  wire rodlq_pkg::cell_ctl_t ctl,
  output rodlq_pkg::entry_t         head
);

  rodlq_pkg::entry_t cell_q [rodlq_pkg::QUEUE_DEPTH];
  rodlq_pkg::entry_t nbr    [rodlq_pkg::QUEUE_DEPTH];

  for (genvar i = 0; i < rodlq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    if (i == rodlq_pkg::QUEUE_DEPTH - 1) begin : g_top
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = cell_q[i+1];
    end

    rodlq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (rodlq_pkg::IDX_W'(i)),
      .nbr_in   (nbr[i]),
      .entry_q  (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

`default_nettype wire

// ----- sv/replace_or_drop_line_queue.sv -----
// Flow: a pop or a disabled push goes from idle straight to the result stage; an
// enabled push first walks the held entries when a replace policy or a full queue
// asks for it, makes one more eviction pass over all QUEUE_DEPTH entries when the
// queue is still full after the purge, and then appends.
// Throughput: one request in work; the next is taken the cycle after its result is parked.
// Reset (synchronous, rst_n low): queue empty, enable set, no result pending.
// ----------------------------------------------------------------------------
// replace_or_drop_line_queue: bounded queue of spoken-line requests
// A chain of slot cells with a walking controller. Pushes may purge queued
// same-group replace entries, evict one entry when full, then append.
// ----------------------------------------------------------------------------
`default_nettype none

module replace_or_drop_line_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: the enable register.
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata fields from bit 0: line_tag[15:0], voice[16], group[24:17],
  // policy[25], zero fill [31:26].
  input  wire logic [31:0] in_tdata,
  // tuser fields from bit 0: op (0 push, 1 pop).
  input  wire logic        in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata fields from bit 0: accepted[0], replaced_count[6:1],
  // overflow_drop[7], head_valid[8], head_tag[24:9], head_voice[25],
  // head_group[33:26], head_policy[34], depth[40:35], zero fill [47:41].
  output logic [47:0]      out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPEND,
    S_OUT
  } state_t;

  localparam int CW = rodlq_pkg::CNT_W;
  localparam int IW = rodlq_pkg::IDX_W;

  // Control state.
  state_t                state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  enable_r;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers of the current request.
  rodlq_pkg::entry_t     req_r, req_nxt;
  logic                  walk2_r, walk2_nxt;     // second pass: eviction
  logic [CW-1:0]         rem_r, rem_nxt;         // entries still to visit
  logic [CW-1:0]         kept_r, kept_nxt;       // entries kept so far
  logic [CW-1:0]         removed_r, removed_nxt; // replace removals
  logic                  any_ovl_r, any_ovl_nxt; // an overlap entry survives
  logic                  evicted_r, evicted_nxt;
  logic                  overflow_r, overflow_nxt;
  rodlq_pkg::result_t    res_r, res_nxt;
  rodlq_pkg::result_t    out_data_r, out_data_nxt;

  rodlq_pkg::cell_ctl_t  ctl;
  rodlq_pkg::entry_t     head;
  rodlq_pkg::entry_t     in_entry;

  logic                  match;
  logic                  drop;
  logic [CW-1:0]         wr_pos;

  rodlq_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign in_entry.tag    = in_tdata[15:0];
  assign in_entry.voice  = in_tdata[16];
  assign in_entry.group  = in_tdata[24:17];
  assign in_entry.policy = in_tdata[25];

  // No request is taken while reset is held.
  assign in_tready  = (state_r == S_IDLE) && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  // During a walk the head entry leaves cell zero every cycle. An entry that
  // stays is written back behind the unvisited ones, right after the entries
  // already kept, so the kept entries end up packed at the head in order.
  always_comb begin
    match = !walk2_r && (req_r.policy == rodlq_pkg::POL_REPLACE) &&
            (head.policy == rodlq_pkg::POL_REPLACE) && (head.group == req_r.group);
    // Eviction takes the oldest overlap entry, or the oldest entry if the
    // queue holds only replace entries.
    if (walk2_r) begin
      drop = !evicted_r && (!any_ovl_r || (head.policy == rodlq_pkg::POL_OVERLAP));
    end else begin
      drop = match;
    end
    wr_pos = rem_r - CW'(1) + kept_r;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    walk2_nxt     = walk2_r;
    rem_nxt       = rem_r;
    kept_nxt      = kept_r;
    removed_nxt   = removed_r;
    any_ovl_nxt   = any_ovl_r;
    evicted_nxt   = evicted_r;
    overflow_nxt  = overflow_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    ctl         = '0;
    ctl.wr_data = head;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = in_entry;
          res_nxt = '0;
          if (in_tuser == rodlq_pkg::OP_POP) begin
            if (fill_r != '0) begin
              ctl.shift           = 1'b1;
              fill_nxt            = fill_r - CW'(1);
              res_nxt.head_valid  = 1'b1;
              res_nxt.head_tag    = head.tag;
              res_nxt.head_voice  = head.voice;
              res_nxt.head_group  = head.group;
              res_nxt.head_policy = head.policy;
              res_nxt.depth       = rodlq_pkg::sat_cnt(fill_r - CW'(1));
            end else begin
              res_nxt.depth = rodlq_pkg::sat_cnt(fill_r);
            end
            state_nxt = S_OUT;
          end else if (!enable_r) begin
            res_nxt.depth = rodlq_pkg::sat_cnt(fill_r);
            state_nxt     = S_OUT;
          end else begin
            walk2_nxt    = 1'b0;
            rem_nxt      = fill_r;
            kept_nxt     = '0;
            removed_nxt  = '0;
            any_ovl_nxt  = 1'b0;
            evicted_nxt  = 1'b0;
            overflow_nxt = 1'b0;
            if ((fill_r != '0) && ((in_entry.policy == rodlq_pkg::POL_REPLACE) ||
                                   (fill_r == rodlq_pkg::FULL_CNT))) begin
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_APPEND;
            end
          end
        end
      end

      S_WALK: begin
        ctl.shift  = 1'b1;
        ctl.wr_en  = !drop;
        ctl.wr_idx = wr_pos[IW-1:0];
        kept_nxt   = kept_r + CW'(!drop);
        rem_nxt    = rem_r - CW'(1);
        if (match) begin
          removed_nxt = removed_r + CW'(1);
        end
        if (!walk2_r && !drop && (head.policy == rodlq_pkg::POL_OVERLAP)) begin
          any_ovl_nxt = 1'b1;
        end
        if (walk2_r && drop) begin
          evicted_nxt  = 1'b1;
          overflow_nxt = 1'b1;
        end
        if (rem_r == CW'(1)) begin
          fill_nxt = kept_nxt;
          if (!walk2_r && (kept_nxt == rodlq_pkg::FULL_CNT)) begin
            // Still full after the purge: one more pass to evict an entry.
            walk2_nxt = 1'b1;
            rem_nxt   = rodlq_pkg::FULL_CNT;
            kept_nxt  = '0;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        ctl.wr_en              = 1'b1;
        ctl.wr_idx             = fill_r[IW-1:0];
        ctl.wr_data            = req_r;
        fill_nxt               = fill_r + CW'(1);
        res_nxt.accepted       = 1'b1;
        res_nxt.replaced_count = rodlq_pkg::sat_cnt(removed_r);
        res_nxt.overflow_drop  = overflow_r;
        res_nxt.depth          = rodlq_pkg::sat_cnt(fill_r + CW'(1));
        state_nxt              = S_OUT;
      end

      S_OUT: begin
        // Park the result in the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
    end
    req_r      <= req_nxt;
    walk2_r    <= walk2_nxt;
    rem_r      <= rem_nxt;
    kept_r     <= kept_nxt;
    removed_r  <= removed_nxt;
    any_ovl_r  <= any_ovl_nxt;
    evicted_r  <= evicted_nxt;
    overflow_r <= overflow_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- verif/tb_replace_or_drop_line_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_replace_or_drop_line_queue: self-checking bench for the line request queue
// Drives push and pop requests over the stream ports and predicts every result
// with a behavioral queue. A directed table comes first, with hand-written
// results for the obvious rows. Random traffic follows under three idle
// patterns.
// ----------------------------------------------------------------------------

module tb_replace_or_drop_line_queue;

  // One row of the directed table. A row with reps above one repeats its
  // request; with step set, the tag and the group count up on each repeat.
  // The field want is a typed-in result, used only where typed is set.
  // Positional order of result_t is depth, head_policy, head_group,
  // head_voice, head_tag, head_valid, overflow_drop, replaced_count, accepted.
  typedef struct {
    logic               en;
    logic               op;
    logic [15:0]        tag;
    logic               voice;
    logic [7:0]         grp;
    logic               pol;
    int                 reps;
    logic               step;
    logic               typed;
    rodlq_pkg::result_t want;
  } plan_row_t;

  localparam rodlq_pkg::result_t NO_RES = '0;
  localparam int PLAN_ROWS = 23;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int EXP_SLOTS = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = rodlq_pkg::OP_PUSH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // Idle rates in percent for the sender and the receiver.
  int in_idle_pct = 38;
  int out_idle_pct = 54;

  // Behavioral copy of the queue and its enable.
  rodlq_pkg::entry_t  model_lines [rodlq_pkg::QUEUE_DEPTH];
  int                 model_fill = 0;
  logic               model_enable = 1'b1;

  // Ring of results still owed by the block, oldest at exp_rd.
  rodlq_pkg::result_t exp_ring [EXP_SLOTS];
  int                 exp_wr = 0;
  int                 exp_rd = 0;
  int                 mismatches = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    // Pop on an empty queue right after reset: everything reads zero.
    '{1'b1, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b1, NO_RES},
    // Extremes of the tag, voice and group on an overlap push.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'hFFFF, 1'b1, 8'hFF, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b1, '{6'd1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0, 1'b1}},
    // Group zero is an ordinary group: the second push replaces the first.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b1, '{6'd2, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h1234, 1'b0, 8'h00, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b1, '{6'd2, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd1, 1'b1}},
    // An overlap entry of the same group survives a replace push.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h00AA, 1'b1, 8'h05, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h00BB, 1'b0, 8'h05, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h00CC, 1'b1, 8'h05, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    // The head is the first line pushed.
    '{1'b1, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b1,
      '{6'd3, rodlq_pkg::POL_OVERLAP, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 6'd0, 1'b0}},
    // Disabled: the push is dropped, the pop still works.
    '{1'b0, rodlq_pkg::OP_PUSH, 16'h5555, 1'b1, 8'h05, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b0, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES},
    // Fill to the top with overlap lines: the next push evicts the oldest overlap line.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h0100, 1'b0, 8'h07, rodlq_pkg::POL_OVERLAP,
      30, 1'b1, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h0200, 1'b1, 8'h09, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h0300, 1'b0, 8'h05, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    // Drain well past empty.
    '{1'b1, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      40, 1'b0, 1'b0, NO_RES},
    // A queue full of replace lines only: eviction falls on the oldest entry.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h1000, 1'b1, 8'h10, rodlq_pkg::POL_REPLACE,
      32, 1'b1, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h8080, 1'b0, 8'h80, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h8181, 1'b1, 8'h11, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES},
    // Replace on a full queue frees a slot, so nothing is evicted.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h2020, 1'b0, 8'h20, rodlq_pkg::POL_REPLACE,
      1, 1'b0, 1'b0, NO_RES},
    // Full again: the lone overlap line in the middle is the victim.
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h3333, 1'b1, 8'h33, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      3, 1'b0, 1'b0, NO_RES},
    '{1'b0, rodlq_pkg::OP_PUSH, 16'hAAAA, 1'b0, 8'hFF, rodlq_pkg::POL_REPLACE,
      2, 1'b1, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_POP, 16'h0000, 1'b0, 8'h00, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES},
    '{1'b1, rodlq_pkg::OP_PUSH, 16'h7FFF, 1'b1, 8'h80, rodlq_pkg::POL_OVERLAP,
      1, 1'b0, 1'b0, NO_RES}
  };

  replace_or_drop_line_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Removes the line at pos from the behavioral queue, closing the gap.
  function automatic void drop_line(input int pos);
    for (int i = pos; i < model_fill - 1; i++) begin
      model_lines[i] = model_lines[i+1];
    end
    model_fill--;
  endfunction

  // Applies one request to the behavioral queue and returns the result the
  // block must produce for it. A replace push first purges queued replace
  // lines of its group; a push that still finds the queue full evicts the
  // oldest overlap line, or the head when there is none.
  function automatic rodlq_pkg::result_t predict_line_result(input logic op,
                                                             input rodlq_pkg::entry_t line);
    rodlq_pkg::result_t r;
    int                 kept;
    int                 removed;
    int                 victim;
    r = '0;
    kept = 0;
    removed = 0;
    victim = -1;
    if (op == rodlq_pkg::OP_PUSH) begin
      if (model_enable) begin
        if (line.policy == rodlq_pkg::POL_REPLACE) begin
          for (int i = 0; i < model_fill; i++) begin
            if ((model_lines[i].policy == rodlq_pkg::POL_REPLACE) &&
                (model_lines[i].group == line.group)) begin
              removed++;
            end else begin
              model_lines[kept] = model_lines[i];
              kept++;
            end
          end
          model_fill = kept;
        end
        if (model_fill >= rodlq_pkg::QUEUE_DEPTH) begin
          for (int i = 0; i < model_fill; i++) begin
            if (victim < 0 && model_lines[i].policy == rodlq_pkg::POL_OVERLAP) begin
              victim = i;
            end
          end
          if (victim < 0) begin
            victim = 0;
          end
          drop_line(victim);
          r.overflow_drop = 1'b1;
        end
        model_lines[model_fill] = line;
        model_fill++;
        r.accepted = 1'b1;
        r.replaced_count = rodlq_pkg::OUT_CNT_W'(removed);
      end
    end else if (model_fill != 0) begin
      r.head_valid  = 1'b1;
      r.head_tag    = model_lines[0].tag;
      r.head_voice  = model_lines[0].voice;
      r.head_group  = model_lines[0].group;
      r.head_policy = model_lines[0].policy;
      drop_line(0);
    end
    r.depth = rodlq_pkg::OUT_CNT_W'(model_fill);
    return r;
  endfunction

  function automatic string show_result(input rodlq_pkg::result_t r);
    return $sformatf({"acc=%0d repl=%0d drop=%0d hv=%0d tag=%h voice=%0d ",
                      "grp=%h pol=%0d depth=%0d"},
                     r.accepted, r.replaced_count, r.overflow_drop, r.head_valid,
                     r.head_tag, r.head_voice, r.head_group, r.head_policy, r.depth);
  endfunction

  // Offers one request, holding it until the block takes it. The expected
  // result is queued at the accepting edge; a typed row overrides the
  // prediction but the behavioral queue still advances.
  task automatic send_request(input logic op, input rodlq_pkg::entry_t line,
                              input logic typed, input rodlq_pkg::result_t want);
    rodlq_pkg::result_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, line};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    r = predict_line_result(op, line);
    exp_ring[exp_wr % EXP_SLOTS] = typed ? want : r;
    exp_wr++;
  endtask

  // The enable is only written once every owed result has come back, so the
  // block is idle. Every request returns a result, so no extra drain is needed
  // beyond a short pause.
  task automatic write_enable(input logic value);
    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_enable = value;
  endtask

  // Random line: the group mostly comes from a small set so that replace
  // pushes find matches, and sometimes from the whole range.
  function automatic rodlq_pkg::entry_t random_line();
    rodlq_pkg::entry_t line;
    line.tag    = 16'($urandom_range(65535));
    line.voice  = 1'($urandom_range(1));
    line.group  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    line.policy = ($urandom_range(99) < 40) ? rodlq_pkg::POL_REPLACE : rodlq_pkg::POL_OVERLAP;
    return line;
  endfunction

  // Random traffic in windows of 64 requests: mostly pushes for the first 44,
  // which drives the queue into its full and evicting states, then mostly
  // pops to drain it again.
  task automatic send_random(input int count);
    int  push_pct;
    logic op;
    for (int k = 0; k < count; k++) begin
      push_pct = (k % 64 < 44) ? 85 : 30;
      op = ($urandom_range(99) < push_pct) ? rodlq_pkg::OP_PUSH : rodlq_pkg::OP_POP;
      send_request(op, random_line(), 1'b0, NO_RES);
    end
  endtask

  // Receiver: checks each accepted result against the oldest expectation and
  // stalls at random by the current rate.
  always @(posedge clk) begin
    rodlq_pkg::result_t got;
    rodlq_pkg::result_t want;
    if (out_tvalid && out_tready) begin
      got = rodlq_pkg::result_t'(out_tdata[40:0]);
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: %s", show_result(got));
        end
      end else begin
        want = exp_ring[exp_rd % EXP_SLOTS];
        exp_rd++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $time);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Main sequence: reset, directed table, then random phases with the idle
  // rates swapped and finally switched off.
  initial begin
    rodlq_pkg::entry_t line;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enable(1'b1);

    foreach (plan[r]) begin
      if (plan[r].en !== model_enable) begin
        write_enable(plan[r].en);
      end
      for (int i = 0; i < plan[r].reps; i++) begin
        line.tag    = plan[r].tag + (plan[r].step ? 16'(i) : 16'd0);
        line.voice  = plan[r].voice;
        line.group  = plan[r].grp + (plan[r].step ? 8'(i) : 8'd0);
        line.policy = plan[r].pol;
        send_request(plan[r].op, line, plan[r].typed, plan[r].want);
      end
    end

    write_enable(1'b1);
    send_random(RANDOM_PER_PHASE);

    // A short disabled stretch: pushes must be dropped, pops still served.
    write_enable(1'b0);
    send_random(12);
    write_enable(1'b1);

    in_idle_pct  = 54;
    out_idle_pct = 38;
    send_random(RANDOM_PER_PHASE);

    write_enable(1'b1);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) begin
      @(posedge clk);
    end
    // The longest walk is two passes; anything later is spurious.
    repeat (80) @(posedge clk);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
